// File: hdl/msgp_pkg.sv
package msgp_pkg;

    localparam int STOP_REGS     = 4;
    localparam int STOP_IDX_W    = $clog2(STOP_REGS);
    localparam int NSTOP_W       = 3;
    localparam int COLOR_W       = 16;
    localparam int CHANNELS      = 3;
    localparam int RGB_W         = COLOR_W * CHANNELS;
    localparam int WEIGHT_W      = 16;
    localparam int TOTAL_W       = WEIGHT_W + 2;
    localparam int IDX_W         = 12;
    localparam int LEN_W         = 13;
    localparam int NUM_W         = WEIGHT_W + LEN_W;
    localparam int CNT_W         = $clog2(NUM_W);
    localparam int DELTA_W       = COLOR_W + 1;
    localparam int PROD_W        = DELTA_W + LEN_W;
    localparam int DIV_STEPS     = COLOR_W + IDX_W;
    localparam int REM_W         = LEN_W;
    localparam int OUT_W         = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    // push edge, pop into multiply stage, divider stages, output register
    localparam int LATENCY       = DIV_STEPS + 3;
    localparam int DEF_MAX_STOPS = 4;
    localparam int DEF_MAX_LINE  = 4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START  = 3'd0,
        REG_STOP0  = 3'd1,
        REG_STOP1  = 3'd2,
        REG_STOP2  = 3'd3,
        REG_STOP3  = 3'd4,
        REG_NSTOPS = 3'd5,
        REG_LENGTH = 3'd6
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_DIV,
        ST_STORE
    } t_setup_state;

    // element 2 is red, 1 green, 0 blue
    typedef logic [CHANNELS-1:0][COLOR_W-1:0] t_color;

    typedef struct packed {
        logic [LEN_W-1:0]                  len;
        logic [NSTOP_W-1:0]                n;
        t_color                            start;
        logic [STOP_REGS-1:0][RGB_W-1:0]   colour;
        logic [STOP_REGS-1:0][LEN_W-1:0]   lo;
        logic [STOP_REGS-1:0][LEN_W-1:0]   hi;
    } t_tab;

    typedef struct packed {
        logic                               oor;
        logic [LEN_W-1:0]                   span;
        logic [IDX_W-1:0]                   off;
        t_color                             pred;
        logic [CHANNELS-1:0][DELTA_W-1:0]   delta;
    } t_item;

    typedef struct packed {
        logic                                 oor;
        logic [LEN_W-1:0]                     span;
        t_color                               pred;
        logic [CHANNELS-1:0]                  neg;
        logic [CHANNELS-1:0][REM_W-1:0]       rem;
        logic [CHANNELS-1:0][DIV_STEPS-1:0]   dq;
    } t_dstage;

    // one restoring division step per channel
    function automatic t_dstage div_step(input t_dstage s);
        t_dstage          r;
        logic [REM_W:0]   t;
        logic             ge;
        r = s;
        for (int c = 0; c < CHANNELS; c++) begin
            t  = {s.rem[c], s.dq[c][DIV_STEPS-1]};
            ge = (t >= {1'b0, s.span});
            r.rem[c] = ge ? REM_W'(t - {1'b0, s.span}) : t[REM_W-1:0];
            r.dq[c]  = {s.dq[c][DIV_STEPS-2:0], ge};
        end
        return r;
    endfunction

endpackage

// File: hdl/msgp_setup.sv
module msgp_setup import msgp_pkg::*; #(
    parameter int MAX_STOPS = DEF_MAX_STOPS,
    parameter int MAX_LINE  = DEF_MAX_LINE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_busy,
    output t_tab                  o_tab
);

    logic [RGB_W-1:0]                      r_start;
    logic [STOP_REGS-1:0][CFG_DATA_W-1:0]  r_stop;
    logic [NSTOP_W-1:0]                    r_nstops;
    logic [LEN_W-1:0]                      r_length;

    t_setup_state                          r_state, n_state;
    logic [STOP_IDX_W-1:0]                 r_k;
    logic [TOTAL_W-1:0]                    r_total;
    logic [NUM_W-1:0]                      r_num;
    logic [TOTAL_W-1:0]                    r_rem;
    logic [CNT_W-1:0]                      r_cnt;
    logic [LEN_W-1:0]                      r_ptr;
    logic [STOP_REGS-1:0][LEN_W-1:0]       r_lo;
    logic [STOP_REGS-1:0][LEN_W-1:0]       r_hi;

    logic [NSTOP_W-1:0]  n_eff;
    logic [LEN_W-1:0]    len_eff;
    logic [TOTAL_W-1:0]  sum;
    logic [TOTAL_W:0]    trial;
    logic                trial_ge;
    logic [LEN_W-1:0]    chunk;
    logic                last;

    always_comb begin
        n_eff = (r_nstops > NSTOP_W'(MAX_STOPS)) ? NSTOP_W'(MAX_STOPS) : r_nstops;
        len_eff = (17'(r_length) > 17'(MAX_LINE)) ? LEN_W'(MAX_LINE) : r_length;
        sum = '0;
        for (int k = 0; k < STOP_REGS; k++) begin
            if (NSTOP_W'(k) < n_eff)
                sum = sum + TOTAL_W'(r_stop[k][CFG_DATA_W-1 -: WEIGHT_W]);
        end
        trial    = {r_rem, r_num[NUM_W-1]};
        trial_ge = (trial >= {1'b0, r_total});
        chunk    = (r_total == '0) ? '0 : r_num[LEN_W-1:0];
        last     = ((NSTOP_W'(r_k) + NSTOP_W'(1)) == n_eff);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_stop   <= '0;
            r_nstops <= '0;
            r_length <= LEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_START:  r_start  <= i_cfg_data[RGB_W-1:0];
                REG_STOP0:  r_stop[0] <= i_cfg_data;
                REG_STOP1:  r_stop[1] <= i_cfg_data;
                REG_STOP2:  r_stop[2] <= i_cfg_data;
                REG_STOP3:  r_stop[3] <= i_cfg_data;
                REG_NSTOPS: r_nstops <= i_cfg_data[NSTOP_W-1:0];
                REG_LENGTH: r_length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= ST_SUM;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  n_state = ST_IDLE;
            ST_SUM:   n_state = (n_eff == '0) ? ST_IDLE : ST_MUL;
            ST_MUL:   n_state = ST_DIV;
            ST_DIV:   n_state = (r_cnt == CNT_W'(NUM_W - 1)) ? ST_STORE : ST_DIV;
            ST_STORE: n_state = last ? ST_IDLE : ST_MUL;
            default:  n_state = ST_IDLE;
        endcase
        // a new write restarts the span table
        if (i_cfg_we)
            n_state = ST_SUM;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_SUM: begin
                r_total <= sum;
                r_k     <= '0;
                r_ptr   <= '0;
            end
            ST_MUL: begin
                r_num <= NUM_W'(r_stop[r_k][CFG_DATA_W-1 -: WEIGHT_W] * len_eff);
                r_rem <= '0;
                r_cnt <= '0;
            end
            ST_DIV: begin
                r_rem <= trial_ge ? TOTAL_W'(trial - {1'b0, r_total}) : trial[TOTAL_W-1:0];
                r_num <= {r_num[NUM_W-2:0], trial_ge};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            ST_STORE: begin
                r_lo[r_k] <= r_ptr;
                r_hi[r_k] <= last ? len_eff : r_ptr + chunk;
                r_ptr     <= r_ptr + chunk;
                r_k       <= r_k + STOP_IDX_W'(1);
            end
            default: ;
        endcase
    end

    always_comb begin
        o_busy      = (r_state != ST_IDLE);
        o_tab.len   = len_eff;
        o_tab.n     = n_eff;
        o_tab.start = r_start;
        o_tab.lo    = r_lo;
        o_tab.hi    = r_hi;
        for (int k = 0; k < STOP_REGS; k++)
            o_tab.colour[k] = r_stop[k][RGB_W-1:0];
    end

endmodule

// File: hdl/msgp_front.sv
module msgp_front import msgp_pkg::*; (
    input  logic [IDX_W-1:0] i_pixel_index,
    input  t_tab             i_tab,
    output t_item            o_item
);

    logic [LEN_W-1:0]                 idx;
    logic                             found;
    t_color                           to;
    t_color                           fb;
    logic [STOP_REGS-1:0][RGB_W-1:0]  prev;

    always_comb begin
        idx = {1'b0, i_pixel_index};
        prev[0] = i_tab.start;
        for (int k = 1; k < STOP_REGS; k++)
            prev[k] = i_tab.colour[k-1];

        found       = 1'b0;
        o_item.oor  = (idx >= i_tab.len);
        o_item.span = '0;
        o_item.off  = '0;
        o_item.pred = i_tab.start;
        to          = i_tab.start;
        fb          = i_tab.start;

        // first span holding the index wins
        for (int k = 0; k < STOP_REGS; k++) begin
            if (NSTOP_W'(k) < i_tab.n) begin
                if (!found && (i_tab.lo[k] <= idx) && (idx < i_tab.hi[k])) begin
                    found       = 1'b1;
                    o_item.span = i_tab.hi[k] - i_tab.lo[k];
                    o_item.off  = IDX_W'(idx - i_tab.lo[k]);
                    o_item.pred = prev[k];
                    to          = i_tab.colour[k];
                end
                if ((NSTOP_W'(k) + NSTOP_W'(1)) == i_tab.n)
                    fb = prev[k];
            end
        end
        // empty last span: hold the previous colour
        if (!found && (i_tab.n != '0)) begin
            o_item.pred = fb;
            to          = fb;
        end

        for (int c = 0; c < CHANNELS; c++)
            o_item.delta[c] = {1'b0, to[c]} - {1'b0, o_item.pred[c]};
    end

endmodule

// File: hdl/msgp_fifo.sv
module msgp_fifo import msgp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_data,
    input  logic   i_pop,
    output logic   o_valid,
    output t_item  o_data
);

    t_item        r_mem [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_count;
    logic         do_pop;

    assign do_pop  = i_pop && (r_count != 2'd0);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push)
                r_wr <= ~r_wr;
            if (do_pop)
                r_rd <= ~r_rd;
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hdl/msgp_back.sv
module msgp_back import msgp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_item             i_item,
    output logic              o_valid,
    output logic [OUT_W-1:0]  o_red_out,
    output logic [OUT_W-1:0]  o_green_out,
    output logic [OUT_W-1:0]  o_blue_out,
    output logic              o_out_of_range
);

    t_dstage                 r_st [DIV_STEPS+1];
    logic [DIV_STEPS:0]      r_vld;
    t_dstage                 head;
    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]       mag;
    t_dstage                 tail;
    logic [DIV_STEPS-1:0]    q;
    logic [DIV_STEPS:0]      qs;
    logic [DIV_STEPS:0]      v;
    logic [CHANNELS-1:0][OUT_W-1:0] pix;

    // multiply stage: signed delta times offset, split into sign and magnitude
    always_comb begin
        head.oor  = i_item.oor;
        head.span = i_item.span;
        head.pred = i_item.pred;
        for (int c = 0; c < CHANNELS; c++) begin
            prod = $signed(i_item.delta[c]) * $signed({1'b0, i_item.off});
            mag  = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
            head.neg[c] = prod[PROD_W-1];
            head.rem[c] = '0;
            head.dq[c]  = mag[DIV_STEPS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= head;
        for (int i = 1; i <= DIV_STEPS; i++)
            r_st[i] <= div_step(r_st[i-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vld <= '0;
        else
            r_vld <= {r_vld[DIV_STEPS-1:0], i_valid};
    end

    // undo the sign, add to the previous colour, keep the high byte (zero when out of range)
    always_comb begin
        tail = r_st[DIV_STEPS];
        for (int c = 0; c < CHANNELS; c++) begin
            q      = (tail.span == '0) ? '0 : tail.dq[c];
            qs     = tail.neg[c] ? (DIV_STEPS+1)'(-{1'b0, q}) : {1'b0, q};
            v      = (DIV_STEPS+1)'(tail.pred[c]) + qs;
            pix[c] = tail.oor ? '0 : v[COLOR_W-1 -: OUT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            o_valid <= 1'b0;
        else
            o_valid <= r_vld[DIV_STEPS];
    end

    always_ff @(posedge i_clk) begin
        o_red_out      <= pix[2];
        o_green_out    <= pix[1];
        o_blue_out     <= pix[0];
        o_out_of_range <= tail.oor;
    end

endmodule

// File: hdl/multi_stop_gradient_pixel.sv
// Channel     Direction  Signals                               Handshake
// ----------  ---------  ------------------------------------  ------------------
// pixel in    in         i_pixel_index                         start && !busy
// colour out  out        o_red_out o_green_out o_blue_out      o_valid, one cycle
//                        o_out_of_range
// config      in         i_cfg_index i_cfg_data                i_cfg_we
//
// One pixel per clock while busy is low; each result passes the queue, the multiplier,
// the 28-stage bit-per-stage divider and the output register.
// After reset and after any config write, busy stays high while the span table
// is rebuilt: a sum step, then per stop a multiply, a serial division and a store.
// The receiver cannot stall; the queue between classifier and multiplier drains
// every cycle.
module multi_stop_gradient_pixel import msgp_pkg::*; #(
    parameter int MAX_STOPS = DEF_MAX_STOPS,
    parameter int MAX_LINE  = DEF_MAX_LINE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [IDX_W-1:0]      i_pixel_index,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output logic [OUT_W-1:0]      o_red_out,
    output logic [OUT_W-1:0]      o_green_out,
    output logic [OUT_W-1:0]      o_blue_out,
    output logic                  o_out_of_range
);

    t_tab   tab;
    t_item  front_item;
    t_item  q_item;
    logic   q_valid;
    logic   accept;

    assign accept = start && !busy;

    msgp_setup #(
        .MAX_STOPS (MAX_STOPS),
        .MAX_LINE  (MAX_LINE)
    ) u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (busy),
        .o_tab       (tab)
    );

    msgp_front u_front (
        .i_pixel_index (i_pixel_index),
        .i_tab         (tab),
        .o_item        (front_item)
    );

    msgp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_item),
        .i_pop   (1'b1),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    msgp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_item         (q_item),
        .o_valid        (o_valid),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_out_of_range (o_out_of_range)
    );

endmodule

// File: hdl/msgp_checker.sv
module msgp_checker import msgp_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  i_cfg_we,
    input logic                  o_valid,
    input logic [OUT_W-1:0]      o_red_out,
    input logic [OUT_W-1:0]      o_green_out,
    input logic [OUT_W-1:0]      o_blue_out,
    input logic                  o_out_of_range
);

    a_oor_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |->
            o_red_out == '0 && o_green_out == '0 && o_blue_out == '0)
        else $error("out-of-range pixel carries colour");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_valid)
        else $error("transaction lost");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without transaction");

    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy)
        else $error("config write did not rebuild span table");

endmodule

bind multi_stop_gradient_pixel msgp_checker u_msgp_checker (.*);
